// ----- hw/rtl/adsr_pkg.sv -----
package adsr_pkg;

  // Field and register widths
  localparam int unsigned LEN_BITS      = 20;
  localparam int unsigned PERIOD_BITS   = 16;
  localparam int unsigned LEVEL_BITS    = 10;
  localparam int unsigned TIME_BITS     = 15;
  localparam int unsigned PROD_BITS     = LEVEL_BITS + TIME_BITS;
  localparam int unsigned QUOT_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 20;
  localparam int unsigned IN_DATA_BITS  = 8;
  localparam int unsigned OUT_DATA_BITS = 32;

  // Parameter defaults
  localparam int unsigned RAMP_ENTRIES_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF   = 20;

  // Arithmetic constants
  localparam int unsigned PERMIL_MAX = 1000;
  localparam int unsigned LOW_MAX    = 32767;

  // Register reset values
  localparam logic [PERIOD_BITS-1:0] PERIOD_RST  = 16'd1852;
  localparam logic [LEVEL_BITS-1:0]  SUSTAIN_RST = 10'd1000;
  localparam logic [LEVEL_BITS-1:0]  VOLUME_RST  = 10'd1000;

  // floor(x/1000) = (x * ceil(2^35/1000)) >> 35, exact for x below 2^25
  localparam logic [25:0] DIV1000_MUL   = 26'd34359739;
  localparam int unsigned DIV1000_SHIFT = 35;

  // Q62 fixed point for the raised-cosine table
  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;
  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PERIOD,
    CFG_NOTE,
    CFG_ATTACK,
    CFG_DECAY,
    CFG_RELEASE,
    CFG_SUSTAIN,
    CFG_VOLUME
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_ROM_ADDR,
    ST_ROM_DATA,
    ST_MUL,
    ST_SCALE,
    ST_FINISH
  } adsr_state_t;

  typedef enum logic [2:0] {
    RG_ATTACK,
    RG_DECAY,
    RG_SUSTAIN,
    RG_RELEASE,
    RG_ZERO
  } region_t;

  typedef enum logic [1:0] {
    PASS_ENV,
    PASS_VOL,
    PASS_HIGH
  } pass_t;

  // Status of the ramp store
  typedef struct packed {
    logic ready;
  } ramp_stat_t;

  function automatic logic [QUOT_BITS-1:0] div1000(input logic [PROD_BITS-1:0] x);
    logic [PROD_BITS+25:0] p;
    p = (PROD_BITS+26)'(x) * (PROD_BITS+26)'(DIV1000_MUL);
    return p[DIV1000_SHIFT +: QUOT_BITS];
  endfunction

  // (a*b) >> 62, product below 4.0 in Q62
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // Taylor series cosine for 0 <= x <= pi/2, elaboration use only
  function automatic logic signed [63:0] cos_q62(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = mul_q62(x, x);
    term = ONE_Q62;
    sum  = $signed(ONE_Q62);
    term = mul_q62(term, x2) / 64'd2;   sum = sum - $signed(term);
    term = mul_q62(term, x2) / 64'd12;  sum = sum + $signed(term);
    term = mul_q62(term, x2) / 64'd30;  sum = sum - $signed(term);
    term = mul_q62(term, x2) / 64'd56;  sum = sum + $signed(term);
    term = mul_q62(term, x2) / 64'd90;  sum = sum - $signed(term);
    term = mul_q62(term, x2) / 64'd132; sum = sum + $signed(term);
    term = mul_q62(term, x2) / 64'd182; sum = sum - $signed(term);
    term = mul_q62(term, x2) / 64'd240; sum = sum + $signed(term);
    term = mul_q62(term, x2) / 64'd306; sum = sum - $signed(term);
    term = mul_q62(term, x2) / 64'd380; sum = sum + $signed(term);
    term = mul_q62(term, x2) / 64'd462; sum = sum - $signed(term);
    term = mul_q62(term, x2) / 64'd552; sum = sum + $signed(term);
    term = mul_q62(term, x2) / 64'd650; sum = sum - $signed(term);
    term = mul_q62(term, x2) / 64'd756; sum = sum + $signed(term);
    term = mul_q62(term, x2) / 64'd870; sum = sum - $signed(term);
    term = mul_q62(term, x2) / 64'd992; sum = sum + $signed(term);
    return sum;
  endfunction

  // Raised-cosine entry i of a table whose last index is last
  function automatic logic [LEVEL_BITS-1:0] ramp_value(input int unsigned i,
                                                       input int unsigned last,
                                                       input logic [63:0] step);
    logic               mirror;
    logic [63:0]        j;
    logic signed [63:0] c;
    logic [63:0]        u;
    logic [63:0]        v;
    mirror = (2 * i > last);
    j      = mirror ? 64'(last - i) : 64'(i);
    c      = cos_q62(step * j);
    if (c < 0) c = '0;
    if (c > $signed(ONE_Q62)) c = $signed(ONE_Q62);
    u = ONE_Q62 - 64'(c);
    v = ((u >> 20) * 64'd500 + (64'd1 << 41)) >> 42;
    return mirror ? LEVEL_BITS'(64'd1000 - v) : LEVEL_BITS'(v);
  endfunction

endpackage

// ----- hw/rtl/adsr_ram.sv -----
module adsr_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/adsr_ramp_store.sv -----
module adsr_ramp_store
  import adsr_pkg::*;
#(
  parameter int unsigned ENTRIES = RAMP_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [LEVEL_BITS-1:0]      rd_data,
  output ramp_stat_t                 stat
);

  localparam int unsigned AW       = $clog2(ENTRIES);
  localparam logic [63:0] RampStep = PI_Q62 / 64'(ENTRIES - 1);

  logic [LEVEL_BITS-1:0] init_tab [ENTRIES];
  logic [AW-1:0]         fill_cnt_r, fill_cnt_nxt;
  logic                  fill_busy_r, fill_busy_nxt;

  // raised-cosine contents, fixed at elaboration
  for (genvar g = 0; g < ENTRIES; g++) begin : g_init
    localparam logic [LEVEL_BITS-1:0] Val = ramp_value(g, ENTRIES - 1, RampStep);
    assign init_tab[g] = Val;
  end

  // load sweep after reset, one entry a cycle
  always_comb begin
    fill_cnt_nxt  = fill_cnt_r;
    fill_busy_nxt = fill_busy_r;
    if (fill_busy_r) begin
      fill_cnt_nxt = fill_cnt_r + 1'b1;
      if (fill_cnt_r == AW'(ENTRIES - 1)) begin
        fill_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      fill_busy_r <= 1'b1;
    end else begin
      fill_cnt_r  <= fill_cnt_nxt;
      fill_busy_r <= fill_busy_nxt;
    end
  end

  adsr_ram #(
    .WIDTH (LEVEL_BITS),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (fill_busy_r),
    .waddr (fill_cnt_r),
    .wdata (init_tab[fill_cnt_r]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign stat.ready = !fill_busy_r;

endmodule

// ----- hw/rtl/adsr_phase_div.sv -----
module adsr_phase_div
  import adsr_pkg::*;
#(
  parameter int unsigned ENTRIES = RAMP_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [LEN_BITS-1:0]        phase,
  input  logic [LEN_BITS-1:0]        len,
  output logic                       done,
  output logic [$clog2(ENTRIES)-1:0] quot
);

  // quotient of phase*(ENTRIES-1)/len, one bit a cycle; phase < len keeps
  // the quotient inside IB bits
  localparam int unsigned IB = $clog2(ENTRIES);
  localparam int unsigned NB = LEN_BITS + IB;
  localparam int unsigned CB = $clog2(IB + 1);

  logic [NB-1:0] rem_r, rem_nxt;
  logic [NB-1:0] dsh_r, dsh_nxt;
  logic [IB-1:0] quot_r, quot_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = NB'(phase) * NB'(ENTRIES - 1);
      dsh_nxt  = NB'(len) << (IB - 1);
      quot_nxt = '0;
      cnt_nxt  = CB'(IB);
    end else if (cnt_r != '0) begin
      if (rem_r >= dsh_r) begin
        rem_nxt  = rem_r - dsh_r;
        quot_nxt = {quot_r[IB-2:0], 1'b1};
      end else begin
        quot_nxt = {quot_r[IB-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CB'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- hw/rtl/adsr_duty_tone_generator_top.sv -----
// ADSR duty tone generator. Each input transfer (in_tdata[0] = restart)
// yields one result transfer: the high and low tick counts of one square-wave
// cycle whose duty follows an attack/decay/sustain/release envelope scaled by
// volume, or note_done on out_tuser once a finite note has run its length.
// Items are handled one at a time. A sustain or silent cycle makes two passes
// through the shared multiply / divide-by-1000 stage. A cycle on a ramp first
// runs the bit-serial ramp index divider and the registered read of the ramp
// memory, then makes three passes on a decay or release ramp and two on an
// attack ramp. A finished note goes straight to the result. After reset the
// ramp memory is loaded with its raised-cosine shape, and no input is taken
// until it is loaded; configuration writes are taken at any time and must
// only be made while the block is idle. The result register lets the next
// input be taken while a result waits on out_tready.
module adsr_duty_tone_generator_top
  import adsr_pkg::*;
#(
  parameter int unsigned RAMP_ENTRIES = RAMP_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [0] restart
  // result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [14:0] high_time, [29:15] low_time
  output logic [0:0]               out_tuser   // [0] note_done
);

  localparam int unsigned IB = $clog2(RAMP_ENTRIES);
  localparam int unsigned WB = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;

  // configuration registers
  logic [PERIOD_BITS-1:0] period_r;
  logic [LEN_BITS-1:0]    note_r, attack_r, decay_r, release_r;
  logic [LEVEL_BITS-1:0]  sustain_r, volume_r;

  // control and datapath
  adsr_state_t            state_r, state_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [COUNT_BITS-1:0]  idx_r, idx_nxt;
  region_t                region_r, region_nxt;
  pass_t                  pass_r, pass_nxt;
  logic [LEVEL_BITS-1:0]  opa_r, opa_nxt;
  logic [TIME_BITS-1:0]   opb_r, opb_nxt;
  logic [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic [TIME_BITS-1:0]   high_r, high_nxt;
  logic                   fin_r, fin_nxt;

  // result register
  logic                   out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;
  logic                   out_user_r;
  logic                   out_free;
  logic                   out_load;
  logic [OUT_DATA_BITS-1:0] out_data_nxt;

  logic                   in_accept;
  logic                   div_start;
  logic                   div_done;
  logic [IB-1:0]          div_quot;
  logic [IB-1:0]          rom_addr;
  logic                   rom_re;
  logic [LEVEL_BITS-1:0]  rom_data;
  ramp_stat_t             rom_stat;

  // classification of the current index
  logic [WB-1:0]          idx_w, note_w, atk_w, dec_end_w, rel_w, sus_end_w;
  logic                   finite, sus_inf;
  logic                   cls_done;
  region_t                cls_region;
  logic [LEN_BITS-1:0]    cls_phase, cls_len;

  logic [LEVEL_BITS-1:0]  sus_sat, vol_sat;
  logic [QUOT_BITS-1:0]   scaled;
  logic [PERIOD_BITS-1:0] low_full;
  logic [TIME_BITS-1:0]   low_time;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PERIOD_RST;
      note_r    <= '0;
      attack_r  <= '0;
      decay_r   <= '0;
      release_r <= '0;
      sustain_r <= SUSTAIN_RST;
      volume_r  <= VOLUME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD:  period_r  <= cfg_wdata[PERIOD_BITS-1:0];
        CFG_NOTE:    note_r    <= cfg_wdata[LEN_BITS-1:0];
        CFG_ATTACK:  attack_r  <= cfg_wdata[LEN_BITS-1:0];
        CFG_DECAY:   decay_r   <= cfg_wdata[LEN_BITS-1:0];
        CFG_RELEASE: release_r <= cfg_wdata[LEN_BITS-1:0];
        CFG_SUSTAIN: sustain_r <= cfg_wdata[LEVEL_BITS-1:0];
        CFG_VOLUME:  volume_r  <= cfg_wdata[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // levels above full scale count as full scale
  assign sus_sat = (sustain_r > LEVEL_BITS'(PERMIL_MAX)) ? LEVEL_BITS'(PERMIL_MAX) : sustain_r;
  assign vol_sat = (volume_r > LEVEL_BITS'(PERMIL_MAX)) ? LEVEL_BITS'(PERMIL_MAX) : volume_r;

  // envelope region and ramp phase
  always_comb begin
    idx_w      = WB'(idx_r);
    note_w     = WB'(note_r);
    atk_w      = WB'(attack_r);
    rel_w      = WB'(release_r);
    dec_end_w  = atk_w + WB'(decay_r);
    finite     = (note_r != '0);
    sus_inf    = !finite;
    sus_end_w  = (rel_w > note_w) ? '0 : (note_w - rel_w);
    cls_done   = finite && (idx_w >= note_w);
    cls_phase  = '0;
    cls_len    = '0;
    if (idx_w < atk_w) begin
      cls_region = RG_ATTACK;
      cls_phase  = LEN_BITS'(idx_w);
      cls_len    = attack_r;
    end else if ((idx_w < dec_end_w) && (decay_r != '0)) begin
      cls_region = RG_DECAY;
      cls_phase  = LEN_BITS'(idx_w - atk_w);
      cls_len    = decay_r;
    end else if (sus_inf || (idx_w < sus_end_w)) begin
      cls_region = RG_SUSTAIN;
    end else if (release_r != '0) begin
      cls_region = RG_RELEASE;
      cls_phase  = LEN_BITS'(idx_w - sus_end_w);
      cls_len    = release_r;
    end else begin
      cls_region = RG_ZERO;
    end
  end

  assign in_tready = (state_r == ST_IDLE) && rom_stat.ready;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign scaled    = div1000(prod_r);
  assign rom_addr  = (div_quot > IB'(RAMP_ENTRIES - 1)) ? IB'(RAMP_ENTRIES - 1) : div_quot;

  // low phase: the rest of the period, floored at zero and clamped
  assign low_full = (period_r >= PERIOD_BITS'(high_r)) ? (period_r - PERIOD_BITS'(high_r)) : '0;
  assign low_time = (low_full > PERIOD_BITS'(LOW_MAX)) ? TIME_BITS'(LOW_MAX)
                                                       : low_full[TIME_BITS-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (cls_done) begin
          state_nxt = ST_FINISH;
        end else if (cls_region inside {RG_SUSTAIN, RG_ZERO}) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) state_nxt = ST_ROM_ADDR;
      end
      ST_ROM_ADDR: state_nxt = ST_ROM_DATA;
      ST_ROM_DATA: state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_SCALE;
      ST_SCALE: begin
        state_nxt = (pass_r == PASS_HIGH) ? ST_FINISH : ST_MUL;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    region_nxt   = region_r;
    pass_nxt     = pass_r;
    opa_nxt      = opa_r;
    opb_nxt      = opb_r;
    prod_nxt     = prod_r;
    high_nxt     = high_r;
    fin_nxt      = fin_r;
    div_start    = 1'b0;
    rom_re       = 1'b0;
    out_load     = 1'b0;
    out_data_nxt = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) idx_nxt = in_tdata[0] ? '0 : count_r;
      end
      ST_CLASSIFY: begin
        fin_nxt    = cls_done;
        region_nxt = cls_region;
        pass_nxt   = PASS_VOL;
        opb_nxt    = TIME_BITS'(vol_sat);
        if (cls_region == RG_SUSTAIN) begin
          opa_nxt = sus_sat;
        end else begin
          opa_nxt = '0;
        end
        div_start = !cls_done && (cls_region inside {RG_ATTACK, RG_DECAY, RG_RELEASE});
      end
      ST_ROM_ADDR: rom_re = 1'b1;
      ST_ROM_DATA: begin
        case (region_r)
          RG_DECAY: begin
            opa_nxt  = LEVEL_BITS'(PERMIL_MAX) - sus_sat;
            opb_nxt  = TIME_BITS'(rom_data);
            pass_nxt = PASS_ENV;
          end
          RG_RELEASE: begin
            opa_nxt  = sus_sat;
            opb_nxt  = TIME_BITS'(LEVEL_BITS'(PERMIL_MAX) - rom_data);
            pass_nxt = PASS_ENV;
          end
          default: begin
            opa_nxt  = rom_data;
            opb_nxt  = TIME_BITS'(vol_sat);
            pass_nxt = PASS_VOL;
          end
        endcase
      end
      ST_MUL: prod_nxt = PROD_BITS'(opa_r) * PROD_BITS'(opb_r);
      ST_SCALE: begin
        case (pass_r)
          PASS_ENV: begin
            opa_nxt  = (region_r == RG_DECAY) ? (LEVEL_BITS'(PERMIL_MAX) - scaled[LEVEL_BITS-1:0])
                                               : scaled[LEVEL_BITS-1:0];
            opb_nxt  = TIME_BITS'(vol_sat);
            pass_nxt = PASS_VOL;
          end
          PASS_VOL: begin
            opa_nxt  = scaled[LEVEL_BITS-1:0];
            opb_nxt  = period_r[PERIOD_BITS-1:1];
            pass_nxt = PASS_HIGH;
          end
          default: begin
            high_nxt = (scaled == '0) ? TIME_BITS'(1) : scaled[TIME_BITS-1:0];
          end
        endcase
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (fin_r) begin
            out_data_nxt = '0;
            count_nxt    = idx_r;
          end else begin
            out_data_nxt = OUT_DATA_BITS'({low_time, high_r});
            count_nxt    = (idx_r != '1) ? (idx_r + 1'b1) : idx_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r    <= idx_nxt;
    region_r <= region_nxt;
    pass_r   <= pass_nxt;
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    prod_r   <= prod_nxt;
    high_r   <= high_nxt;
    fin_r    <= fin_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= fin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  adsr_phase_div #(
    .ENTRIES (RAMP_ENTRIES)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .phase (cls_phase),
    .len   (cls_len),
    .done  (div_done),
    .quot  (div_quot)
  );

  adsr_ramp_store #(
    .ENTRIES (RAMP_ENTRIES)
  ) u_ramp (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rom_re),
    .rd_addr (rom_addr),
    .rd_data (rom_data),
    .stat    (rom_stat)
  );

endmodule

// ----- tb/adsr_duty_tone_generator_top_tb.sv -----
module adsr_duty_tone_generator_top_tb;
  import adsr_pkg::*;

  // Index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;

  localparam int SETTLE_CYCLES     = 30;
  localparam int END_CYCLES        = 50;
  localparam int STALL_LIMIT       = 3000;
  localparam int RANDOM_SETTINGS   = 9;
  localparam int ITEMS_PER_SETTING = 82;

  typedef struct packed {
    logic [TIME_BITS-1:0] high_time;
    logic [TIME_BITS-1:0] low_time;
    logic                 note_done;
  } tone_t;

  // Envelope predictor plus queue of tone cycles still to arrive
  class tone_scoreboard;
    localparam int RAMP_LAST = RAMP_ENTRIES_DEF - 1;

    logic [LEVEL_BITS-1:0]  ramp [RAMP_ENTRIES_DEF];
    logic [PERIOD_BITS-1:0] period_ticks;
    logic [LEN_BITS-1:0]    note_len;
    logic [LEN_BITS-1:0]    attack_len;
    logic [LEN_BITS-1:0]    decay_len;
    logic [LEN_BITS-1:0]    release_len;
    logic [LEVEL_BITS-1:0]  sustain_lvl;
    logic [LEVEL_BITS-1:0]  volume_lvl;
    logic [COUNT_BITS_DEF-1:0] cycle_count;
    tone_t                  expected_tones[$];
    int                     errors;

    function new();
      period_ticks = PERIOD_RST;
      note_len     = '0;
      attack_len   = '0;
      decay_len    = '0;
      release_len  = '0;
      sustain_lvl  = SUSTAIN_RST;
      volume_lvl   = VOLUME_RST;
      cycle_count  = '0;
      errors       = 0;
      build_ramp();
    endfunction

    // (a*b) >> 62 in Q62
    function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    // Taylor cosine up to the x^32 term, 0 <= x <= pi/2
    function logic signed [63:0] q62_cos(logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x2   = q62_mul(x, x);
      term = ONE_Q62;
      sum  = $signed(ONE_Q62);
      for (int k = 1; k <= 16; k++) begin
        term = q62_mul(term, x2) / 64'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      return sum;
    endfunction

    // Raised-cosine table, upper half mirrored from the lower half
    function void build_ramp();
      logic [63:0]        step_q;
      logic [63:0]        j;
      logic [63:0]        u;
      logic [63:0]        v;
      logic signed [63:0] c;
      logic               mirror;
      step_q = PI_Q62 / 64'(RAMP_LAST);
      for (int i = 0; i < RAMP_ENTRIES_DEF; i++) begin
        mirror = (2 * i > RAMP_LAST);
        j      = mirror ? 64'(RAMP_LAST - i) : 64'(i);
        c      = q62_cos(step_q * j);
        if (c < 0) c = '0;
        if (c > $signed(ONE_Q62)) c = $signed(ONE_Q62);
        u = ONE_Q62 - 64'(c);
        v = ((u >> 20) * 64'd500 + (64'd1 << 41)) >> 42;
        ramp[i] = mirror ? LEVEL_BITS'(64'd1000 - v) : LEVEL_BITS'(v);
      end
    endfunction

    function logic [63:0] ramp_at(logic [63:0] phase, logic [63:0] len);
      logic [63:0] a;
      a = phase * 64'(RAMP_LAST) / len;
      if (a > 64'(RAMP_LAST)) a = 64'(RAMP_LAST);
      return 64'(ramp[a[7:0]]);
    endfunction

    function void configure(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_PERIOD:  period_ticks = data[PERIOD_BITS-1:0];
        CFG_NOTE:    note_len     = data[LEN_BITS-1:0];
        CFG_ATTACK:  attack_len   = data[LEN_BITS-1:0];
        CFG_DECAY:   decay_len    = data[LEN_BITS-1:0];
        CFG_RELEASE: release_len  = data[LEN_BITS-1:0];
        CFG_SUSTAIN: sustain_lvl  = data[LEVEL_BITS-1:0];
        CFG_VOLUME:  volume_lvl   = data[LEVEL_BITS-1:0];
        default: ;
      endcase
    endfunction

    // One accepted request: work out its tone cycle and advance the counter
    function void predict_cycle(logic restart);
      logic [63:0] idx;
      logic [63:0] atk_end;
      logic [63:0] dec_end;
      logic [63:0] sus_end;
      logic [63:0] amplitude;
      logic [63:0] amp;
      logic [63:0] high;
      logic [63:0] low;
      logic [63:0] sus;
      logic [63:0] vol;
      logic        finite;
      tone_t       r;
      sus    = (sustain_lvl > 10'd1000) ? 64'd1000 : 64'(sustain_lvl);
      vol    = (volume_lvl > 10'd1000) ? 64'd1000 : 64'(volume_lvl);
      finite = (note_len != '0);
      if (restart) cycle_count = '0;
      idx = 64'(cycle_count);

      // finished note: no cycle, counter holds
      if (finite && idx >= 64'(note_len)) begin
        r.high_time = '0;
        r.low_time  = '0;
        r.note_done = 1'b1;
        expected_tones.push_back(r);
        return;
      end

      atk_end = 64'(attack_len);
      dec_end = atk_end + 64'(decay_len);
      if (!finite) sus_end = '1;
      else if (release_len > note_len) sus_end = '0;
      else sus_end = 64'(note_len - release_len);

      if (idx < atk_end) begin
        amplitude = ramp_at(idx, atk_end);
      end else if (idx < dec_end && decay_len != '0) begin
        amplitude = 64'd1000 - (64'd1000 - sus) * ramp_at(idx - atk_end, 64'(decay_len))
                    / 64'd1000;
      end else if (idx < sus_end) begin
        amplitude = sus;
      end else if (release_len != '0) begin
        amplitude = sus * (64'd1000 - ramp_at(idx - sus_end, 64'(release_len))) / 64'd1000;
      end else begin
        amplitude = '0;
      end

      amp  = amplitude * vol / 64'd1000;
      high = amp * 64'(period_ticks / 16'd2) / 64'd1000;
      if (high < 64'd1) high = 64'd1;
      low = (64'(period_ticks) >= high) ? 64'(period_ticks) - high : '0;
      if (low > 64'(LOW_MAX)) low = 64'(LOW_MAX);

      r.high_time = high[TIME_BITS-1:0];
      r.low_time  = low[TIME_BITS-1:0];
      r.note_done = 1'b0;
      expected_tones.push_back(r);

      if (cycle_count != '1) cycle_count = cycle_count + 1'b1;
    endfunction

    function void check_tone(logic [OUT_DATA_BITS-1:0] data, logic [0:0] user);
      tone_t e;
      if (expected_tones.size() == 0) begin
        $error("unexpected result: high_time %0d low_time %0d note_done %0d",
               data[14:0], data[29:15], user[0]);
        errors++;
        return;
      end
      e = expected_tones.pop_front();
      if (data[14:0] !== e.high_time) begin
        $error("high_time mismatch: expected %0d, actual %0d", e.high_time, data[14:0]);
        errors++;
      end
      if (data[29:15] !== e.low_time) begin
        $error("low_time mismatch: expected %0d, actual %0d", e.low_time, data[29:15]);
        errors++;
      end
      if (user[0] !== e.note_done) begin
        $error("note_done mismatch: expected %0d, actual %0d", e.note_done, user[0]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_tones.size();
    endfunction
  endclass

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata  = '0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [0:0]               out_tuser;

  tone_scoreboard sb;
  int             tx_idle_pct  = 16;
  int             rx_idle_pct  = 87;
  int             stall_cycles = 0;

  adsr_duty_tone_generator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] restart
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [14:0] high_time, [29:15] low_time
    .out_tuser  (out_tuser)    // [0] note_done
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor: predict on each request transfer, check each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.predict_cycle(in_tdata[0]);
      if (out_tvalid && out_tready) sb.check_tone(out_tdata, out_tuser);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input logic restart);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_BITS'(restart);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off requests until every predicted cycle has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.configure(idx, data);
    @(posedge clk);
  endtask

  // Reprogram every register while the block sits idle
  task automatic apply_setting(input logic [19:0] period_v, input logic [19:0] note_v,
                               input logic [19:0] attack_v, input logic [19:0] decay_v,
                               input logic [19:0] rel_v, input logic [19:0] sustain_v,
                               input logic [19:0] volume_v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
    write_reg(CFG_PERIOD, period_v);
    write_reg(CFG_NOTE, note_v);
    write_reg(CFG_ATTACK, attack_v);
    write_reg(CFG_DECAY, decay_v);
    write_reg(CFG_RELEASE, rel_v);
    write_reg(CFG_SUSTAIN, sustain_v);
    write_reg(CFG_VOLUME, volume_v);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [19:0] random_level();
    int sel;
    sel = $urandom_range(5);
    if (sel == 0) return 20'(1000 + $urandom_range(23));
    if (sel == 1) return 20'd0;
    // junk above the 10-bit register must be dropped
    return {10'($urandom), 10'($urandom_range(1000))};
  endfunction

  task automatic random_setting();
    logic [19:0] period_v;
    logic [19:0] note_v;
    logic [19:0] attack_v;
    logic [19:0] decay_v;
    logic [19:0] rel_v;
    int          sel;
    int          span;
    sel = $urandom_range(7);
    if (sel == 0) period_v = 20'd2;
    else if (sel == 1) period_v = 20'd65535;
    else period_v = {4'($urandom), 16'($urandom_range(2, 65535))};

    sel = $urandom_range(9);
    if (sel == 0) note_v = '0;
    else if (sel == 1) note_v = 20'($urandom_range(1, 1048575));
    else note_v = 20'($urandom_range(1, 48));
    span = (note_v == 0 || note_v > 64) ? 32 : int'(note_v);

    attack_v = ($urandom_range(5) == 0) ? 20'($urandom) : 20'($urandom_range(0, span / 2));
    decay_v  = ($urandom_range(5) == 0) ? 20'($urandom) : 20'($urandom_range(0, span / 2));
    sel = $urandom_range(5);
    if (sel == 0) rel_v = '0;
    else if (sel == 1) rel_v = note_v + 20'($urandom_range(1, 8));
    else rel_v = 20'($urandom_range(0, span));

    apply_setting(period_v, note_v, attack_v, decay_v, rel_v, random_level(), random_level());
  endtask

  // Notes: a restart, then a run of steps, with stray restarts as noise
  task automatic play_notes(input int count);
    int sent;
    int run;
    int reach;
    sent = 0;
    while (sent < count) begin
      send_item(1'b1);
      sent++;
      reach = (sb.note_len == 0 || sb.note_len > 60) ? 40 : int'(sb.note_len) + 3;
      run   = $urandom_range(1, reach);
      for (int k = 0; k < run && sent < count; k++) begin
        send_item($urandom_range(19) == 0);
        sent++;
      end
      if ($urandom_range(15) == 0) drain_results();
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: indefinite note held at full sustain
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);

    // full ADSR over a short note, longest period, volume above full scale
    apply_setting(20'd65535, 20'd10, 20'd3, 20'd2, 20'd3, 20'd400, 20'd1023);
    send_item(1'b1);
    repeat (5) send_item(1'b0);
    drain_results();
    repeat (6) send_item(1'b0);

    // shortest period, release longer than the note, zero volume
    apply_setting(20'd2, 20'd4, 20'd0, 20'd0, 20'd9, 20'd1023, 20'd0);
    send_item(1'b1);
    repeat (4) send_item(1'b0);

    // longest ramps on an indefinite note, silent sustain
    apply_setting(20'd1000, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'd500);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);

    // random settings, three idling regimes
    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      if (p < 3) begin
        tx_idle_pct = 16;
        rx_idle_pct = 87;
      end else if (p < 6) begin
        tx_idle_pct = 87;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_setting();
      play_notes(ITEMS_PER_SETTING);
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
